/* rtl/core/clipped_pixel_store_rect_fill_core_defines.svh */
// Assertion macros used by the checker file of the pixel store core.
`ifndef CLIPPED_PIXEL_STORE_RECT_FILL_CORE_DEFINES_SVH
`define CLIPPED_PIXEL_STORE_RECT_FILL_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CPSRF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CPSRF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/cpsrf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package cpsrf_pkg;

   localparam int MAX_WIDTH_DEF  = 64;
   localparam int MAX_HEIGHT_DEF = 64;

   localparam int KIND_W  = 2;
   localparam int FRAME_W = 7;
   localparam int COORD_W = 16;
   localparam int SUM_W   = COORD_W + 1;
   localparam int PIXEL_W = 32;
   localparam int LIN_W   = 2 * FRAME_W;
   localparam int CSR_IDX_W = 2;

   localparam logic [FRAME_W-1:0] FRAME_RESET = FRAME_W'(64);

   localparam logic [KIND_W-1:0] REQ_SET   = 2'd0;
   localparam logic [KIND_W-1:0] REQ_GET   = 2'd1;
   localparam logic [KIND_W-1:0] REQ_FILL  = 2'd2;
   localparam logic [KIND_W-1:0] REQ_CLEAR = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 2'd1;

   typedef struct packed {
      logic load;    // latch the request and its clipped bounds
      logic step;    // write the current pixel and advance the scan
      logic read;    // read the current pixel
      logic emit;    // load the response register
   } cmd_type;

   typedef struct packed {
      logic load_empty;   // the request just offered touches no pixel
      logic load_get;     // the request just offered is a get
      logic last_pixel;   // the scan stands on the last pixel of the rectangle
   } status_type;

endpackage

`default_nettype wire

/* rtl/core/clipped_pixel_store_rect_fill_core.sv */
`timescale 1ns / 1ps
`default_nettype none

// Framebuffer of 32-bit pixels, MAX_WIDTH by MAX_HEIGHT entries in one
// single-port memory, row-major under the configured frame width. Requests
// set, get, fill a rectangle or clear the frame; anything outside the frame
// is skipped, and a get outside it returns zero. The memory holds garbage after
// reset, so issue a clear before the first get. One request is handled at a
// time: a set or get uses a write or read state, a fill or clear writes each
// pixel inside the frame in the write state, and a request touching no pixel
// skips to the done state. The single memory write port, one pixel per cycle,
// sets the fill rate. The response sits in an output register, so a new
// request is accepted while the previous response is still stalled. Frame
// width and height may be written only while no request is in flight.
module clipped_pixel_store_rect_fill_core #(
   parameter int MAX_WIDTH  = cpsrf_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = cpsrf_pkg::MAX_HEIGHT_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_wr_en,
   input  wire logic [cpsrf_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [cpsrf_pkg::FRAME_W-1:0]     csr_wdata,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [cpsrf_pkg::KIND_W-1:0]      req_type,
   input  wire logic [cpsrf_pkg::COORD_W-1:0]     req_pos_x,
   input  wire logic [cpsrf_pkg::COORD_W-1:0]     req_pos_y,
   input  wire logic [cpsrf_pkg::COORD_W-1:0]     req_rect_w,
   input  wire logic [cpsrf_pkg::COORD_W-1:0]     req_rect_h,
   input  wire logic [cpsrf_pkg::PIXEL_W-1:0]     req_pixel_color,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [cpsrf_pkg::PIXEL_W-1:0]          rsp_read_data,
   output logic                                   rsp_op_done
);
   import cpsrf_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Every request completes, so the done flag is constant.
   assign rsp_op_done = 1'b1;

   cpsrf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   cpsrf_dpath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_type        (req_type),
      .req_pos_x       (req_pos_x),
      .req_pos_y       (req_pos_y),
      .req_rect_w      (req_rect_w),
      .req_rect_h      (req_rect_h),
      .req_pixel_color (req_pixel_color),
      .cmd             (cmd),
      .status          (status),
      .rsp_read_data   (rsp_read_data)
   );

endmodule

`default_nettype wire

/* rtl/core/cpsrf_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module cpsrf_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   input  wire cpsrf_pkg::status_type status,
   output cpsrf_pkg::cmd_type         cmd
);
   import cpsrf_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_WRITE = 2'd1;
   localparam logic [1:0] ST_READ  = 2'd2;
   localparam logic [1:0] ST_DONE  = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       slot_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               if (status.load_empty) begin
                  state_in = ST_DONE;
               end else if (status.load_get) begin
                  state_in = ST_READ;
               end else begin
                  state_in = ST_WRITE;
               end
            end
         end
         ST_WRITE: begin
            cmd.step = 1'b1;
            if (status.last_pixel) begin
               state_in = ST_DONE;
            end
         end
         ST_READ: begin
            cmd.read = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // The response waits here until the output register can take it.
            if (slot_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/cpsrf_dpath.sv */
`timescale 1ns / 1ps
`default_nettype none

module cpsrf_dpath #(
   parameter int MAX_WIDTH  = cpsrf_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = cpsrf_pkg::MAX_HEIGHT_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_wr_en,
   input  wire logic [cpsrf_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [cpsrf_pkg::FRAME_W-1:0]       csr_wdata,
   input  wire logic [cpsrf_pkg::KIND_W-1:0]        req_type,
   input  wire logic [cpsrf_pkg::COORD_W-1:0]       req_pos_x,
   input  wire logic [cpsrf_pkg::COORD_W-1:0]       req_pos_y,
   input  wire logic [cpsrf_pkg::COORD_W-1:0]       req_rect_w,
   input  wire logic [cpsrf_pkg::COORD_W-1:0]       req_rect_h,
   input  wire logic [cpsrf_pkg::PIXEL_W-1:0]       req_pixel_color,
   input  wire cpsrf_pkg::cmd_type                  cmd,
   output cpsrf_pkg::status_type                    status,
   output logic [cpsrf_pkg::PIXEL_W-1:0]            rsp_read_data
);
   import cpsrf_pkg::*;

   localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [PIXEL_W-1:0] mem [DEPTH];

   logic [FRAME_W-1:0] frame_w_ff, frame_h_ff;
   logic [FRAME_W-1:0] eff_w, eff_h;

   logic [FRAME_W-1:0] x_cur_ff, y_cur_ff, x_start_ff, x_end_ff, y_end_ff;
   logic [PIXEL_W-1:0] color_ff;
   logic               is_get_ff, empty_ff;
   logic [PIXEL_W-1:0] rd_data_ff;
   logic [PIXEL_W-1:0] rsp_data_ff;

   logic [COORD_W-1:0] ld_x0, ld_y0, ld_w, ld_h;
   logic [SUM_W-1:0]   sum_x, sum_y;
   logic [FRAME_W-1:0] ld_x_end, ld_y_end;
   logic               ld_empty;

   logic [FRAME_W:0]   x_next, y_next;
   logic               x_last, y_last;
   logic [LIN_W-1:0]   lin_addr;
   logic [ADDR_W-1:0]  addr;

   // A frame register above the built size acts as the built size.
   assign eff_w = (32'(frame_w_ff) > MAX_WIDTH)  ? FRAME_W'(MAX_WIDTH)  : frame_w_ff;
   assign eff_h = (32'(frame_h_ff) > MAX_HEIGHT) ? FRAME_W'(MAX_HEIGHT) : frame_h_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_w_ff <= FRAME_RESET;
         frame_h_ff <= FRAME_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:  frame_w_ff <= csr_wdata;
            CSR_FRAME_HEIGHT: frame_h_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Every request becomes a rectangle: set and get cover one pixel, clear the
   // whole frame. The end sums are one bit wider than the coordinates.
   always_comb begin
      ld_x0 = req_pos_x;
      ld_y0 = req_pos_y;
      ld_w  = COORD_W'(1);
      ld_h  = COORD_W'(1);
      unique case (req_type) inside
         REQ_SET, REQ_GET: begin
            ld_w = COORD_W'(1);
            ld_h = COORD_W'(1);
         end
         REQ_FILL: begin
            ld_w = req_rect_w;
            ld_h = req_rect_h;
         end
         REQ_CLEAR: begin
            ld_x0 = '0;
            ld_y0 = '0;
            ld_w  = COORD_W'(eff_w);
            ld_h  = COORD_W'(eff_h);
         end
         default: ;
      endcase
      sum_x    = SUM_W'(ld_x0) + SUM_W'(ld_w);
      sum_y    = SUM_W'(ld_y0) + SUM_W'(ld_h);
      ld_x_end = (sum_x > SUM_W'(eff_w)) ? eff_w : sum_x[FRAME_W-1:0];
      ld_y_end = (sum_y > SUM_W'(eff_h)) ? eff_h : sum_y[FRAME_W-1:0];
      ld_empty = (ld_x0 >= COORD_W'(ld_x_end)) || (ld_y0 >= COORD_W'(ld_y_end));
   end

   assign x_next = {1'b0, x_cur_ff} + 1'b1;
   assign y_next = {1'b0, y_cur_ff} + 1'b1;
   assign x_last = (x_next == {1'b0, x_end_ff});
   assign y_last = (y_next == {1'b0, y_end_ff});

   assign lin_addr = LIN_W'(y_cur_ff) * LIN_W'(eff_w) + LIN_W'(x_cur_ff);
   assign addr     = ADDR_W'(lin_addr);

   assign status.load_empty = ld_empty;
   assign status.load_get   = (req_type == REQ_GET);
   assign status.last_pixel = x_last && y_last;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x_cur_ff   <= ld_x0[FRAME_W-1:0];
         y_cur_ff   <= ld_y0[FRAME_W-1:0];
         x_start_ff <= ld_x0[FRAME_W-1:0];
         x_end_ff   <= ld_x_end;
         y_end_ff   <= ld_y_end;
         color_ff   <= req_pixel_color;
         is_get_ff  <= (req_type == REQ_GET);
         empty_ff   <= ld_empty;
      end else if (cmd.step) begin
         if (x_last) begin
            x_cur_ff <= x_start_ff;
            y_cur_ff <= y_next[FRAME_W-1:0];
         end else begin
            x_cur_ff <= x_next[FRAME_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.step) begin
         mem[addr] <= color_ff;
      end
      if (cmd.read) begin
         rd_data_ff <= mem[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_data_ff <= (is_get_ff && !empty_ff) ? rd_data_ff : '0;
      end
   end

   assign rsp_read_data = rsp_data_ff;

endmodule

`default_nettype wire

/* rtl/core/cpsrf_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

`include "clipped_pixel_store_rect_fill_core_defines.svh"

module cpsrf_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_stall,
   input wire logic rsp_valid,
   input wire logic rsp_stall,
   input wire logic rsp_op_done
);

   `CPSRF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid, "response dropped while stalled")

   `CPSRF_ASSERT_NOW(a_done_set, clock, reset, rsp_valid, rsp_op_done, "response without done flag")

   // Only one request is in flight, so the port closes right after a transaction.
   `CPSRF_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && !req_stall, req_stall, "request port open while busy")

   // A new response only follows work on a request.
   `CPSRF_ASSERT_NOW(a_rsp_from_req, clock, reset, $rose(rsp_valid), $past(req_stall), "response without a request")

endmodule

bind clipped_pixel_store_rect_fill_core cpsrf_checker u_checker (.*);

`default_nettype wire

/* tb/pixel_store_checker.sv */
`timescale 1ns / 1ps

// Watches the register port and both channels of the pixel store, keeps a
// shadow frame, and compares every response transaction with the oldest
// predicted one.
module pixel_store_checker
   import cpsrf_pkg::*;
#(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [FRAME_W-1:0]   csr_wdata,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  logic [KIND_W-1:0]    req_type,
   input  logic [COORD_W-1:0]   req_pos_x,
   input  logic [COORD_W-1:0]   req_pos_y,
   input  logic [COORD_W-1:0]   req_rect_w,
   input  logic [COORD_W-1:0]   req_rect_h,
   input  logic [PIXEL_W-1:0]   req_pixel_color,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  logic [PIXEL_W-1:0]   rsp_read_data,
   input  logic                 rsp_op_done,
   output int                   mismatch_count,
   output int                   in_flight
);

   logic [PIXEL_W-1:0] shadow_frame [0:MAX_WIDTH*MAX_HEIGHT-1];
   logic [FRAME_W-1:0] cols_reg;
   logic [FRAME_W-1:0] rows_reg;
   logic [PIXEL_W-1:0] expected_read_q [$];
   int n_errors = 0;
   int pending = 0;

   assign mismatch_count = n_errors;
   assign in_flight      = pending;

   // Register values above the built size act as the built size.
   function automatic int frame_cols();
      return (cols_reg > MAX_WIDTH) ? MAX_WIDTH : int'(cols_reg);
   endfunction

   function automatic int frame_rows();
      return (rows_reg > MAX_HEIGHT) ? MAX_HEIGHT : int'(rows_reg);
   endfunction

   task automatic report_mismatch(input string what, input logic [PIXEL_W-1:0] got,
                                  input logic [PIXEL_W-1:0] want);
      $display("[%0t] mismatch on %s: got 0x%08h, expected 0x%08h", $time, what, got, want);
      n_errors = n_errors + 1;
   endtask

   // Ends are clipped on plain integers, so a large origin plus a large
   // extent cannot wrap back into the frame.
   task automatic paint_rect(input int x0, input int y0, input int w, input int h,
                             input logic [PIXEL_W-1:0] color);
      int x_end;
      int y_end;
      x_end = x0 + w;
      y_end = y0 + h;
      if (x_end > frame_cols()) x_end = frame_cols();
      if (y_end > frame_rows()) y_end = frame_rows();
      for (int yy = y0; yy < y_end; yy++)
         for (int xx = x0; xx < x_end; xx++)
            shadow_frame[yy * frame_cols() + xx] = color;
   endtask

   task automatic serve_request(input logic [KIND_W-1:0] kind,
                                input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                                input logic [COORD_W-1:0] w, input logic [COORD_W-1:0] h,
                                input logic [PIXEL_W-1:0] color,
                                output logic [PIXEL_W-1:0] data);
      int col;
      int row;
      bit hit;
      col  = int'(x);
      row  = int'(y);
      hit  = (col < frame_cols()) && (row < frame_rows());
      data = '0;
      case (kind)
         REQ_SET: begin
            if (hit) shadow_frame[row * frame_cols() + col] = color;
         end
         REQ_GET: begin
            if (hit) data = shadow_frame[row * frame_cols() + col];
         end
         REQ_FILL: begin
            paint_rect(col, row, int'(w), int'(h), color);
         end
         default: begin
            paint_rect(0, 0, frame_cols(), frame_rows(), color);
         end
      endcase
   endtask

   always @(posedge clock) begin
      logic [PIXEL_W-1:0] want;
      if (reset) begin
         cols_reg = FRAME_RESET;
         rows_reg = FRAME_RESET;
         expected_read_q.delete();
         pending <= 0;
      end else begin
         if (csr_wr_en) begin
            if (csr_index == CSR_FRAME_WIDTH) cols_reg = csr_wdata;
            else if (csr_index == CSR_FRAME_HEIGHT) rows_reg = csr_wdata;
         end
         // A response can leave in the same cycle as the next request enters,
         // and it always belongs to an earlier request.
         if (rsp_valid && !rsp_stall) begin
            if (expected_read_q.size() == 0) begin
               report_mismatch("unexpected response", rsp_read_data, '0);
            end else begin
               want = expected_read_q.pop_front();
               if (rsp_read_data !== want) report_mismatch("read_data", rsp_read_data, want);
               if (rsp_op_done !== 1'b1) begin
                  report_mismatch("op_done", PIXEL_W'(rsp_op_done), PIXEL_W'(1'b1));
               end
            end
         end
         if (req_valid && !req_stall) begin
            serve_request(req_type, req_pos_x, req_pos_y, req_rect_w, req_rect_h,
                          req_pixel_color, want);
            expected_read_q.push_back(want);
         end
         pending <= expected_read_q.size();
      end
   end

endmodule

/* tb/clipped_pixel_store_rect_fill_core_test.sv */
`timescale 1ns / 1ps

module clipped_pixel_store_rect_fill_core_test;
   import cpsrf_pkg::*;

   localparam int CYCLE_LIMIT     = 5_000_000;
   localparam int PHASES          = 8;
   localparam int ITEMS_PER_PHASE = 238;

   // Indexes past the two frame registers must be ignored by the block.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 2'd3;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_FRAME_WIDTH;
   logic [FRAME_W-1:0]   csr_wdata = '0;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [KIND_W-1:0]    req_type = REQ_SET;
   logic [COORD_W-1:0]   req_pos_x = '0;
   logic [COORD_W-1:0]   req_pos_y = '0;
   logic [COORD_W-1:0]   req_rect_w = '0;
   logic [COORD_W-1:0]   req_rect_h = '0;
   logic [PIXEL_W-1:0]   req_pixel_color = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [PIXEL_W-1:0]   rsp_read_data;
   logic                 rsp_op_done;

   int mismatch_count;
   int in_flight;
   int cycle_count = 0;
   int n_kind [4] = '{0, 0, 0, 0};
   int n_settings = 0;
   int cur_cols = 64;
   int cur_rows = 64;
   int send_calm = 0;
   int stall_left = 0;
   int calm_left = 0;
   bit no_idling = 1'b0;

   clipped_pixel_store_rect_fill_core u_dut (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_type        (req_type),
      .req_pos_x       (req_pos_x),
      .req_pos_y       (req_pos_y),
      .req_rect_w      (req_rect_w),
      .req_rect_h      (req_rect_h),
      .req_pixel_color (req_pixel_color),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_read_data   (rsp_read_data),
      .rsp_op_done     (rsp_op_done)
   );

   pixel_store_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_type        (req_type),
      .req_pos_x       (req_pos_x),
      .req_pos_y       (req_pos_y),
      .req_rect_w      (req_rect_w),
      .req_rect_h      (req_rect_h),
      .req_pixel_color (req_pixel_color),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_read_data   (rsp_read_data),
      .rsp_op_done     (rsp_op_done),
      .mismatch_count  (mismatch_count),
      .in_flight       (in_flight)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Receiver back-pressure: stall bursts of random length between calm
   // stretches of random length, some of them long, and none under no_idling.
   always @(posedge clock) begin
      if (no_idling) begin
         stall_left = 0;
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_stall <= 1'b1;
      end else if (calm_left > 0) begin
         calm_left = calm_left - 1;
         rsp_stall <= 1'b0;
      end else begin
         stall_left = $urandom_range(1, 7) - 1;
         calm_left  = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 300)
                                                   : $urandom_range(0, 12);
         rsp_stall <= 1'b1;
      end
   end

   // Called only while no transaction is in flight.
   task automatic set_frame(input logic [FRAME_W-1:0] cols, input logic [FRAME_W-1:0] rows);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_FRAME_WIDTH;
      csr_wdata <= cols;
      @(posedge clock);
      csr_index <= CSR_FRAME_HEIGHT;
      csr_wdata <= rows;
      @(posedge clock);
      csr_index <= ($urandom_range(0, 1) == 0) ? CSR_SPARE_LO : CSR_SPARE_HI;
      csr_wdata <= FRAME_W'($urandom());
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cur_cols   = int'(cols);
      cur_rows   = int'(rows);
      n_settings = n_settings + 1;
   endtask

   task automatic send(input logic [KIND_W-1:0] kind,
                       input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                       input logic [COORD_W-1:0] w, input logic [COORD_W-1:0] h,
                       input logic [PIXEL_W-1:0] color);
      if (!no_idling) begin
         if (send_calm > 0) begin
            send_calm = send_calm - 1;
         end else begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
            send_calm = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 150)
                                                     : $urandom_range(0, 4);
         end
      end
      req_valid       <= 1'b1;
      req_type        <= kind;
      req_pos_x       <= x;
      req_pos_y       <= y;
      req_rect_w      <= w;
      req_rect_h      <= h;
      req_pixel_color <= color;
      do @(posedge clock); while (req_stall !== 1'b0);
      n_kind[kind] = n_kind[kind] + 1;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (in_flight != 0);
   endtask

   // Mostly in or just past the frame, sometimes anywhere in the 16-bit range.
   function automatic logic [COORD_W-1:0] pick_coord(input int span);
      if ($urandom_range(0, 4) == 0) return COORD_W'($urandom());
      return COORD_W'($urandom_range(0, span + 1));
   endfunction

   task automatic send_random_item();
      int cols;
      int rows;
      int pick;
      logic [KIND_W-1:0] kind;
      logic [COORD_W-1:0] w;
      logic [COORD_W-1:0] h;
      cols = (cur_cols > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : cur_cols;
      rows = (cur_rows > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : cur_rows;
      pick = $urandom_range(0, 99);
      if (pick < 2) kind = REQ_CLEAR;
      else if (pick < 37) kind = REQ_SET;
      else if (pick < 67) kind = REQ_GET;
      else kind = REQ_FILL;
      // Most rectangles are small to keep the run short; a few cover the frame.
      pick = $urandom_range(0, 99);
      if (pick < 85) begin
         w = COORD_W'($urandom_range(0, 6));
         h = COORD_W'($urandom_range(0, 6));
      end else if (pick < 95) begin
         w = COORD_W'($urandom_range(0, 70));
         h = COORD_W'($urandom_range(0, 70));
      end else begin
         w = COORD_W'($urandom());
         h = COORD_W'($urandom());
      end
      send(kind, pick_coord(cols), pick_coord(rows), w, h, $urandom());
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      set_frame(7'd64, 7'd64);

      // The first clear covers every entry, so no later get sees an unwritten one.
      send(REQ_CLEAR, 16'd0, 16'd0, 16'd0, 16'd0, 32'hA5A5_5A5A);
      send(REQ_SET, 16'd0, 16'd0, 16'd0, 16'd0, 32'hFFFF_FFFF);
      send(REQ_SET, 16'd63, 16'd63, 16'hFFFF, 16'hFFFF, 32'h0000_0000);
      send(REQ_SET, 16'd64, 16'd0, 16'd0, 16'd0, 32'h1234_5678);
      send(REQ_SET, 16'd0, 16'd64, 16'd0, 16'd0, 32'h8765_4321);
      send(REQ_SET, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 32'hDEAD_BEEF);
      send(REQ_GET, 16'd0, 16'd0, 16'd0, 16'd0, 32'd0);
      send(REQ_GET, 16'd63, 16'd63, 16'd0, 16'd0, 32'd0);
      send(REQ_GET, 16'd64, 16'd0, 16'd0, 16'd0, 32'd0);
      send(REQ_GET, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 32'd0);
      send(REQ_GET, 16'd5, 16'd5, 16'd0, 16'd0, 32'd0);
      send(REQ_FILL, 16'd10, 16'd10, 16'd0, 16'd5, 32'h0BAD_0001);
      send(REQ_FILL, 16'd10, 16'd10, 16'd5, 16'd0, 32'h0BAD_0002);
      send(REQ_FILL, 16'd60, 16'd61, 16'hFFFF, 16'hFFFF, 32'h5555_AAAA);
      send(REQ_FILL, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'h0BAD_0003);
      send(REQ_FILL, 16'd0, 16'd1, 16'd3, 16'd2, 32'hC0DE_0042);
      send(REQ_GET, 16'd61, 16'd62, 16'd0, 16'd0, 32'd0);
      send(REQ_GET, 16'd1, 16'd1, 16'd0, 16'd0, 32'd0);

      // An empty frame: nothing is written and every get answers zero.
      wait_drained();
      set_frame(7'd0, 7'd64);
      send(REQ_SET, 16'd0, 16'd0, 16'd0, 16'd0, 32'h0BAD_0004);
      send(REQ_GET, 16'd0, 16'd0, 16'd0, 16'd0, 32'd0);
      send(REQ_FILL, 16'd0, 16'd0, 16'd5, 16'd5, 32'h0BAD_0005);
      send(REQ_CLEAR, 16'd0, 16'd0, 16'd0, 16'd0, 32'h0BAD_0006);

      // Oversized registers act as the built size; then a narrower row
      // length reinterprets what is already stored.
      wait_drained();
      set_frame(7'd127, 7'd127);
      send(REQ_GET, 16'd63, 16'd63, 16'd0, 16'd0, 32'd0);
      send(REQ_CLEAR, 16'd0, 16'd0, 16'd0, 16'd0, 32'h3C3C_C3C3);
      wait_drained();
      set_frame(7'd10, 7'd64);
      send(REQ_GET, 16'd3, 16'd2, 16'd0, 16'd0, 32'd0);

      for (int phase = 0; phase < PHASES; phase++) begin
         wait_drained();
         case (phase)
            0: begin
               set_frame(7'd64, 7'd64);
            end
            1: begin
               set_frame(7'd1, 7'd1);
            end
            3: begin
               set_frame(7'd64, 7'd1);
            end
            4: begin
               set_frame(7'd1, 7'd64);
            end
            5: begin
               set_frame(7'($urandom_range(65, 127)), 7'($urandom_range(65, 127)));
            end
            6: begin
               set_frame(7'($urandom_range(1, 64)), 7'd0);
            end
            default: begin
               set_frame(7'($urandom_range(1, 64)), 7'($urandom_range(1, 64)));
            end
         endcase
         if (phase == PHASES - 1) no_idling <= 1'b1;
         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            // Hold the sender back once until every response is out.
            if (phase == 2 && i == ITEMS_PER_PHASE / 2) wait_drained();
            send_random_item();
         end
      end

      wait_drained();
      repeat (20) @(posedge clock);
      $display("Covered %0d set, %0d get, %0d fill and %0d clear transactions",
               n_kind[REQ_SET], n_kind[REQ_GET], n_kind[REQ_FILL], n_kind[REQ_CLEAR]);
      $display("under %0d frame settings, empty, one-pixel and oversized frames among them.",
               n_settings);
      if (mismatch_count == 0 && in_flight == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

/* clipped_pixel_store_rect_fill_core.f */
+incdir+rtl/core
rtl/core/cpsrf_pkg.sv
rtl/core/cpsrf_ctrl.sv
rtl/core/cpsrf_dpath.sv
rtl/core/clipped_pixel_store_rect_fill_core.sv
rtl/core/cpsrf_checker.sv
tb/pixel_store_checker.sv
tb/clipped_pixel_store_rect_fill_core_test.sv
